// ----- src/tpra_pkg.sv -----
// Shared constants, codes and controller/datapath interface types for the packet ring allocator.
package tpra_pkg;

    localparam int FLEN_W  = 11;
    localparam int LEN_W   = 12;
    localparam int ADDR_W  = 13;
    localparam int PEND_W  = 12;
    localparam int KIND_W  = 2;
    localparam int STAT_W  = 2;

    localparam int SDATA_W = 16;
    localparam int MDATA_W = 56;

    localparam int TX_REGION_BYTES_DEF = 4096;

    localparam logic [PEND_W-1:0] PEND_MAX = 12'd4095;
    localparam logic [LEN_W-1:0]  HDR_BYTES = 12'd10;
    localparam logic [ADDR_W-1:0] STATUS_GAP = 13'd8;
    localparam logic [ADDR_W-1:0] LEN_WORD_BYTES = 13'd2;

    localparam logic [KIND_W-1:0] KIND_ENQ    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TXDONE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LINK   = 2'd2;

    localparam logic [STAT_W-1:0] STAT_DONE    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOLINK  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOSPACE = 2'd2;
    localparam logic [STAT_W-1:0] STAT_IGNORED = 2'd3;

    typedef struct packed {
        logic capture;
        logic exec;
        logic tx_load;
        logic load_out;
    } tpra_cmd_t;

    typedef struct packed {
        logic advance;
    } tpra_stat_t;

endpackage

// ----- src/tpra_ctrl.sv -----
// Sequencer for the packet ring allocator: handshakes and per-item step control.
module tpra_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  tpra_pkg::tpra_stat_t stat,
    output tpra_pkg::tpra_cmd_t  cmd
);
    import tpra_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXEC = 3'd1;
    localparam logic [2:0] ST_READ = 3'd2;
    localparam logic [2:0] ST_LOAD = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        cmd.capture  = s_tvalid && (state_reg == ST_IDLE);
        cmd.exec     = (state_reg == ST_EXEC);
        cmd.tx_load  = (state_reg == ST_LOAD);
        cmd.load_out = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                state_next = stat.advance ? ST_READ : ST_DONE;
            end
            ST_READ:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || m_tready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- src/tpra_dpath.sv -----
// Ring pointers, length store and result registers of the packet ring allocator.
module tpra_dpath #(
    parameter int TX_REGION_BYTES = tpra_pkg::TX_REGION_BYTES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [tpra_pkg::SDATA_W-1:0] s_tdata,
    input  logic [tpra_pkg::KIND_W-1:0]  s_tuser,
    output logic [tpra_pkg::MDATA_W-1:0] m_tdata,
    output logic [tpra_pkg::STAT_W-1:0]  m_tuser,
    input  tpra_pkg::tpra_cmd_t          cmd,
    output tpra_pkg::tpra_stat_t         stat
);
    import tpra_pkg::*;

    localparam int PW = $clog2(TX_REGION_BYTES + 2);
    localparam int SW = ((PW > LEN_W) ? PW : LEN_W) + 1;
    localparam int IW = PW - 1;
    localparam int LEN_DEPTH = TX_REGION_BYTES / 2 + 1;
    localparam logic [SW-1:0] REGION = SW'(TX_REGION_BYTES);

    // item
    logic [KIND_W-1:0] kind_reg;
    logic [FLEN_W-1:0] flen_reg;
    logic              lup_reg;

    // ring state
    logic              linked_reg, linked_next;
    logic [PEND_W-1:0] pend_reg, pend_next;
    logic [PW-1:0]     sp_reg, sp_next;
    logic [PW-1:0]     wp_reg, wp_next;
    logic [PW-1:0]     wm_reg, wm_next;
    logic [LEN_W-1:0]  cur_len_reg, cur_len_next;

    logic [LEN_W-1:0]  len_mem [LEN_DEPTH];
    logic [LEN_W-1:0]  rd_len_reg;
    logic              mem_we;

    // results
    logic [STAT_W-1:0] res_status_reg, res_status_next;
    logic [ADDR_W-1:0] res_daddr_reg, res_daddr_next;
    logic              res_stx_reg, res_stx_next;
    logic [ADDR_W-1:0] res_txs_reg, res_txs_next;
    logic [ADDR_W-1:0] res_txe_reg, res_txe_next;

    logic [STAT_W-1:0] out_status_reg;
    logic [ADDR_W-1:0] out_daddr_reg;
    logic              out_stx_reg;
    logic [ADDR_W-1:0] out_txs_reg;
    logic [ADDR_W-1:0] out_txe_reg;
    logic [PEND_W-1:0] out_pend_reg;

    // enqueue fit check
    logic [LEN_W-1:0] tot;
    logic [SW-1:0]    tot_s, sp_s, wp_s, room, sum_wp, wpw, wp_end, wp_even;
    logic             fits, wrapped, pend_zero;

    // advance
    logic [SW-1:0] sp_adv, sp_even;

    assign pend_zero = (pend_reg == '0);
    assign tot    = LEN_W'(flen_reg) + HDR_BYTES;
    assign tot_s  = SW'(tot);
    assign sp_s   = pend_zero ? '0 : SW'(sp_reg);
    assign wp_s   = pend_zero ? '0 : SW'(wp_reg);
    assign room   = (wp_s <= REGION) ? (REGION - wp_s) : '0;
    assign sum_wp = wp_s + tot_s;

    always_comb
    begin
        fits    = 1'b0;
        wrapped = 1'b0;
        if (pend_zero)
            fits = (tot_s <= REGION);
        else if (wp_s < sp_s)
            fits = (sum_wp <= sp_s);
        else if (wp_s > sp_s)
        begin
            if (tot_s > room)
            begin
                // no room at the end: restart at zero if it fits before the start
                if (tot_s <= sp_s)
                begin
                    fits    = 1'b1;
                    wrapped = 1'b1;
                end
            end
            else
                fits = 1'b1;
        end
    end

    assign wpw     = wrapped ? '0 : wp_s;
    assign wp_end  = wpw + tot_s;
    assign wp_even = wp_end + SW'(wp_end[0]);

    assign sp_adv  = SW'(sp_reg) + SW'(cur_len_reg);
    assign sp_even = sp_adv + SW'(sp_adv[0]);

    assign stat.advance = (kind_reg == KIND_TXDONE) && (pend_reg > PEND_W'(1));

    always_comb
    begin
        linked_next     = linked_reg;
        pend_next       = pend_reg;
        sp_next         = sp_reg;
        wp_next         = wp_reg;
        wm_next         = wm_reg;
        cur_len_next    = cur_len_reg;
        mem_we          = 1'b0;
        res_status_next = res_status_reg;
        res_daddr_next  = res_daddr_reg;
        res_stx_next    = res_stx_reg;
        res_txs_next    = res_txs_reg;
        res_txe_next    = res_txe_reg;

        if (cmd.exec)
        begin
            res_status_next = STAT_DONE;
            res_daddr_next  = '0;
            res_stx_next    = 1'b0;
            res_txs_next    = '0;
            res_txe_next    = '0;
            case (kind_reg)
                KIND_ENQ:
                begin
                    if (!linked_reg)
                        res_status_next = STAT_NOLINK;
                    else if (pend_reg == PEND_MAX)
                        res_status_next = STAT_NOSPACE;
                    else
                    begin
                        if (pend_zero)
                        begin
                            sp_next = '0;
                            wp_next = '0;
                            wm_next = PW'(REGION);
                        end
                        if (!fits)
                            res_status_next = STAT_NOSPACE;
                        else
                        begin
                            res_daddr_next = ADDR_W'(wpw + SW'(2));
                            if (pend_zero)
                            begin
                                res_stx_next = 1'b1;
                                res_txs_next = LEN_WORD_BYTES;
                                res_txe_next = ADDR_W'(tot) - STATUS_GAP;
                                cur_len_next = tot;
                            end
                            else
                                mem_we = 1'b1;
                            wp_next = PW'(wp_even);
                            if (wrapped)
                                wm_next = wp_reg;
                            pend_next = pend_reg + PEND_W'(1);
                        end
                    end
                end
                KIND_TXDONE:
                begin
                    if (pend_zero)
                        res_status_next = STAT_IGNORED;
                    else
                    begin
                        pend_next = pend_reg - PEND_W'(1);
                        if (stat.advance)
                        begin
                            // follow the wrap marker back to zero
                            if (sp_even == SW'(wm_reg))
                            begin
                                wm_next = PW'(REGION);
                                sp_next = '0;
                            end
                            else
                                sp_next = PW'(sp_even);
                        end
                    end
                end
                KIND_LINK:
                begin
                    linked_next = lup_reg;
                    if (lup_reg)
                    begin
                        pend_next    = '0;
                        sp_next      = '0;
                        wp_next      = '0;
                        wm_next      = PW'(REGION);
                        cur_len_next = '0;
                    end
                end
                default:
                begin
                    res_status_next = STAT_IGNORED;
                end
            endcase
        end
        else if (cmd.tx_load)
        begin
            cur_len_next = rd_len_reg;
            res_stx_next = 1'b1;
            res_txs_next = ADDR_W'(sp_reg) + LEN_WORD_BYTES;
            res_txe_next = ADDR_W'(sp_reg) + ADDR_W'(rd_len_reg) - STATUS_GAP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            linked_reg  <= 1'b0;
            pend_reg    <= '0;
            sp_reg      <= '0;
            wp_reg      <= '0;
            wm_reg      <= PW'(REGION);
            cur_len_reg <= '0;
        end
        else
        begin
            linked_reg  <= linked_next;
            pend_reg    <= pend_next;
            sp_reg      <= sp_next;
            wp_reg      <= wp_next;
            wm_reg      <= wm_next;
            cur_len_reg <= cur_len_next;
        end
    end

    // length store: one write port, one registered read at the start pointer
    always_ff @(posedge clk)
    begin
        if (mem_we)
            len_mem[wpw[IW:1]] <= tot;
        rd_len_reg <= len_mem[sp_reg[IW:1]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= s_tuser;
            flen_reg <= s_tdata[FLEN_W-1:0];
            lup_reg  <= s_tdata[FLEN_W];
        end
        res_status_reg <= res_status_next;
        res_daddr_reg  <= res_daddr_next;
        res_stx_reg    <= res_stx_next;
        res_txs_reg    <= res_txs_next;
        res_txe_reg    <= res_txe_next;
        if (cmd.load_out)
        begin
            out_status_reg <= res_status_reg;
            out_daddr_reg  <= res_daddr_reg;
            out_stx_reg    <= res_stx_reg;
            out_txs_reg    <= res_txs_reg;
            out_txe_reg    <= res_txe_reg;
            out_pend_reg   <= pend_reg;
        end
    end

    assign m_tuser = out_status_reg;
    assign m_tdata = {4'b0, out_pend_reg, out_txe_reg, out_txs_reg, out_stx_reg, out_daddr_reg};

endmodule

// ----- src/tx_packet_ring_allocator_core.sv -----
// Top level of the transmit packet ring allocator.
//
// Input stream (s_*): one transfer per event. s_tuser carries the kind (enqueue,
// transmit done, link event); s_tdata carries the frame length and the new link
// state. Output stream (m_*): exactly one result transfer per input transfer, in
// order. m_tuser carries the status; m_tdata carries data address, start flag,
// transmit start and end addresses and the pending count.
// Order: an enqueue, link event or ignored item passes the execute and done states
// before m_tvalid rises; a transmit done that starts the next packet also passes the
// read and load states for the registered read of the length store. Input is taken
// one item at a time: s_tready is high only in the idle state, so a new item waits
// until the done state has loaded the previous result into the output register.
// Reset: link down, ring empty, pointers at zero, wrap marker at region end. The
// length store is not cleared; only entries written by enqueues are ever read.
// Stall: a result waits in the output register while m_tready is low; the block
// still takes and works one more item, then holds it until the register frees.
module tx_packet_ring_allocator_core #(
    parameter int TX_REGION_BYTES = tpra_pkg::TX_REGION_BYTES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [tpra_pkg::SDATA_W-1:0] s_tdata,   // frame_len[10:0], link_up[11], zero pad
    input  logic [tpra_pkg::KIND_W-1:0]  s_tuser,   // kind[1:0]
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // data_addr[12:0], start_tx[13], tx_start[26:14], tx_end[39:27], pending[51:40], pad
    output logic [tpra_pkg::MDATA_W-1:0] m_tdata,
    output logic [tpra_pkg::STAT_W-1:0]  m_tuser    // status[1:0]
);
    import tpra_pkg::*;

    tpra_cmd_t  cmd;
    tpra_stat_t stat;

    tpra_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tpra_dpath #(
        .TX_REGION_BYTES (TX_REGION_BYTES)
    ) u_dpath (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .cmd     (cmd),
        .stat    (stat)
    );

endmodule
